// File: hw/rtl/aorb_pkg.sv
// Package with the format codes and the channel blend arithmetic of the ARGB over RGB565 blender.
package aorb_pkg;

  typedef enum logic [1:0] {
    FMT_RGB565   = 2'd0,
    FMT_RGB888   = 2'd1,
    FMT_ARGB8888 = 2'd2,
    FMT_RESERVED = 2'd3
  } src_fmt_t;

  localparam int unsigned SrcWordWidth = 32;
  localparam int unsigned PixelWidth   = 16;
  localparam int unsigned ChanWidth    = 6;
  localparam int unsigned AlphaWidth   = 8;
  localparam int unsigned ProdWidth    = ChanWidth + AlphaWidth;
  localparam int unsigned SInDataWidth = SrcWordWidth + PixelWidth;
  localparam logic [AlphaWidth-1:0] AlphaMax = 8'd255;

  // Exact floor(x / 255) for x below 64 * 255, using x / 255 = (x + x / 256 + 1) / 256.
  function automatic logic [ChanWidth-1:0] div255(input logic [ProdWidth-1:0] x);
    logic [ProdWidth:0] sum;
    sum = {1'b0, x} + {9'd0, x[ProdWidth-1:8]} + {{ProdWidth{1'b0}}, 1'b1};
    return sum[ProdWidth-1:8];
  endfunction

  // Blends one channel; the sum of the two truncated quotients never exceeds the channel maximum.
  function automatic logic [ChanWidth-1:0] blend_ch(input logic [ChanWidth-1:0]  s,
                                                    input logic [ChanWidth-1:0]  d,
                                                    input logic [AlphaWidth-1:0] a);
    logic [ProdWidth-1:0] ps;
    logic [ProdWidth-1:0] pd;
    ps = ProdWidth'(s) * ProdWidth'(a);
    pd = ProdWidth'(d) * ProdWidth'(AlphaMax - a);
    return div255(ps) + div255(pd);
  endfunction

endpackage

// File: hw/rtl/argb_over_rgb565_blend_top.sv
// Top level of the ARGB over RGB565 blender: input register, blend logic and result register.
//
//  Channel   Direction  Handshake          Payload
//  s_axis    in         tvalid / tready    tdata[47:0] = src_word[31:0], dst_pixel[47:32]
//  m_axis    out        tvalid / tready    tdata[15:0] = out_pixel
//  cfg       in         cfg_wr_en          cfg_wr_data[1:0] = source_format
//
// One pixel per clock is sustained while m_axis_tready is held high; an accepted transaction
// is captured in the input register and, once the result register can advance, passes through
// the blend logic into the result register, from which it is offered on m_axis.
// Reset clears both valid flags and returns source_format to the 16 bpp copy mode.
// When the result register is stalled, the input register still takes one more transaction if it is empty.
module argb_over_rgb565_blend_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // src_word[31:0], dst_pixel[47:32]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // out_pixel[15:0]
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_wr_data
);

  aorb_pkg::src_fmt_t source_format;

  logic                                in_valid;
  logic [aorb_pkg::SrcWordWidth-1:0]   in_src;
  logic [aorb_pkg::PixelWidth-1:0]     in_dst;
  logic                                out_valid;
  logic [aorb_pkg::PixelWidth-1:0]     out_pixel;
  logic [aorb_pkg::PixelWidth-1:0]     out_pixel_next;
  logic                                adv;
  logic [aorb_pkg::ChanWidth-1:0]      red_mix;
  logic [aorb_pkg::ChanWidth-1:0]      grn_mix;
  logic [aorb_pkg::ChanWidth-1:0]      blu_mix;

  assign adv           = !out_valid || m_axis_tready;
  assign s_axis_tready = !in_valid || adv;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_pixel;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_format <= aorb_pkg::FMT_RGB565;
    end else if (cfg_wr_en) begin
      source_format <= aorb_pkg::src_fmt_t'(cfg_wr_data);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_src <= s_axis_tdata[aorb_pkg::SrcWordWidth-1:0];
      in_dst <= s_axis_tdata[aorb_pkg::SInDataWidth-1:aorb_pkg::SrcWordWidth];
    end
  end

  assign red_mix = aorb_pkg::blend_ch({1'b0, in_src[15:11]}, {1'b0, in_dst[15:11]}, in_src[7:0]);
  assign grn_mix = aorb_pkg::blend_ch(in_src[23:18], in_dst[10:5], in_src[7:0]);
  assign blu_mix = aorb_pkg::blend_ch({1'b0, in_src[31:27]}, {1'b0, in_dst[4:0]}, in_src[7:0]);

  always_comb begin
    case (source_format)
      aorb_pkg::FMT_RGB565: begin
        out_pixel_next = in_src[15:0];
      end
      aorb_pkg::FMT_RGB888: begin
        out_pixel_next = {in_src[7:3], in_src[15:10], in_src[23:19]};
      end
      aorb_pkg::FMT_ARGB8888: begin
        out_pixel_next = {red_mix[4:0], grn_mix, blu_mix[4:0]};
      end
      default: begin
        out_pixel_next = in_dst;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && adv) begin
      out_pixel <= out_pixel_next;
    end
  end

`ifndef SYNTHESIS
  a_moves_to_output: assert property (@(posedge clk) disable iff (rst)
    in_valid && adv |=> out_valid)
    else $error("Input register content did not reach the result register.");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> in_valid && out_valid && !m_axis_tready)
    else $error("Input side stalled while the pipeline had room.");

  a_reserved_keeps_dst: assert property (@(posedge clk) disable iff (rst)
    in_valid && adv && source_format == aorb_pkg::FMT_RESERVED
    |=> m_axis_tdata == $past(in_dst))
    else $error("Reserved format did not pass the destination pixel through.");
`endif

endmodule
